// ----- rtl/core/psplit_pkg.sv -----
// Shared types, constants and helpers of the Pascal lexeme splitter.
`timescale 1ns / 1ps
`default_nettype none

package psplit_pkg;

    localparam int CHAR_W  = 8;
    localparam int ACT_W   = 2;
    localparam int LINE_W  = 16;
    localparam int COL_W   = 10;
    localparam int DEPTH_W = 8;
    localparam int LEN_W   = 6;
    localparam int IDX_W   = 5;

    localparam int DEF_MAX_LEXEME   = 32;
    localparam int DEF_LINE_COLUMNS = 1024;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [CHAR_W-1:0] CH_LBRACE  = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE  = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_LESS    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GREATER = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_EQUAL   = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_SEMI    = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

    typedef enum logic [ACT_W-1:0] {
        ACT_CHAR = 2'd0,
        ACT_EOL  = 2'd1,
        ACT_EOI  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_COLON   = 2'd1,
        PEND_LESS    = 2'd2,
        PEND_GREATER = 2'd3
    } t_pend;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PEND1,
        BK_PEND2,
        BK_FLUSH_RD,
        BK_FLUSH_OUT,
        BK_SINGLE,
        BK_END
    } t_back_state;

    // one request's work for the back end; w on pop, the rest in field order
    typedef struct packed {
        logic              p_valid;
        logic              p_pair;
        logic [CHAR_W-1:0] p_char;
        logic [CHAR_W-1:0] p_second;
        logic [COL_W-1:0]  p_col;
        logic              f_valid;
        logic [LEN_W-1:0]  f_len;
        logic [COL_W-1:0]  f_col;
        logic              f_ovf;
        logic              s_valid;
        logic [CHAR_W-1:0] s_char;
        logic [COL_W-1:0]  s_col;
        logic              e_valid;
        logic              w_valid;
        logic [IDX_W-1:0]  w_idx;
        logic [CHAR_W-1:0] w_char;
        logic [LINE_W-1:0] line;
    } t_cmd;

    typedef struct packed {
        logic [CHAR_W-1:0] lex_char;
        logic              first_char;
        logic              last_char;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        logic              end_of_input;
        logic              truncated;
    } t_lex;

    function automatic logic [CHAR_W-1:0] pend_char(input t_pend p);
        logic [CHAR_W-1:0] c;
        unique case (p)
            PEND_COLON: c = CH_COLON;
            PEND_LESS:  c = CH_LESS;
            default:    c = CH_GREATER;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/psplit_in_if.sv -----
// Request channel carrying source characters and line/input markers.
`timescale 1ns / 1ps
`default_nettype none

interface psplit_in_if;
    logic                         valid;
    logic                         ready;
    logic [psplit_pkg::ACT_W-1:0]  action;
    logic [psplit_pkg::CHAR_W-1:0] ch;

    modport source (output valid, output action, output ch, input ready);
    modport sink   (input valid, input action, input ch, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/psplit_out_if.sv -----
// Result channel carrying lexeme characters with their position tags.
`timescale 1ns / 1ps
`default_nettype none

interface psplit_out_if;
    logic                          valid;
    logic                          ready;
    logic [psplit_pkg::CHAR_W-1:0] lex_char;
    logic                          first_char;
    logic                          last_char;
    logic [psplit_pkg::LINE_W-1:0] line;
    logic [psplit_pkg::COL_W-1:0]  column;
    logic                          end_of_input;
    logic                          truncated;

    modport source (output valid, output lex_char, output first_char, output last_char,
                    output line, output column, output end_of_input, output truncated,
                    input ready);
    modport sink   (input valid, input lex_char, input first_char, input last_char,
                    input line, input column, input end_of_input, input truncated,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/psplit_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module psplit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/psplit_cmd_fifo.sv -----
// Short command queue between the classifying front end and the emitting back end.
`timescale 1ns / 1ps
`default_nettype none

module psplit_cmd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  psplit_pkg::t_cmd i_cmd,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output psplit_pkg::t_cmd o_cmd
);

    localparam int DEPTH = psplit_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    psplit_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/psplit_front.sv -----
// Front end: tracks position, comments and pending operators, and classifies each request.
`timescale 1ns / 1ps
`default_nettype none

module psplit_front #(
    parameter int MAX_LEXEME   = psplit_pkg::DEF_MAX_LEXEME,
    parameter int LINE_COLUMNS = psplit_pkg::DEF_LINE_COLUMNS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    psplit_in_if.sink        i_req,
    input  logic             i_q_full,
    output logic             o_push,
    output psplit_pkg::t_cmd o_cmd
);

    localparam int CW    = $clog2(LINE_COLUMNS);
    localparam int LW    = $clog2(MAX_LEXEME + 1);
    localparam int COL_W = psplit_pkg::COL_W;

    logic [psplit_pkg::DEPTH_W-1:0] r_depth, n_depth;
    logic [LW-1:0]                  r_len, n_len;
    logic [COL_W-1:0]               r_start, n_start;
    logic                           r_ovf, n_ovf;
    psplit_pkg::t_pend              r_pend, n_pend;
    logic [COL_W-1:0]               r_pcol, n_pcol;
    logic [psplit_pkg::CHAR_W-1:0]  r_prev, n_prev;
    logic                           r_prev_valid, n_prev_valid;
    logic [psplit_pkg::LINE_W-1:0]  r_line, n_line;
    logic [CW-1:0]                  r_col, n_col;

    logic [COL_W+CW-1:0]            col_ext;
    logic [COL_W-1:0]               col10;
    logic [psplit_pkg::CHAR_W-1:0]  c;
    logic                           accept;
    logic                           pend_hit;
    logic                           prev_digit;
    logic                           do_flush, do_single, do_append;
    psplit_pkg::t_cmd               cmd;

    assign i_req.ready = !i_q_full;
    assign accept      = i_req.valid && !i_q_full;
    assign c           = i_req.ch;
    assign col_ext     = {{COL_W{1'b0}}, r_col};
    assign col10       = col_ext[COL_W-1:0];
    assign prev_digit  = r_prev_valid && (r_prev >= psplit_pkg::CH_ZERO)
                         && (r_prev <= psplit_pkg::CH_NINE);
    assign pend_hit    = (r_pend != psplit_pkg::PEND_NONE)
                         && ((c == psplit_pkg::CH_EQUAL)
                             || ((r_pend == psplit_pkg::PEND_LESS)
                                 && (c == psplit_pkg::CH_GREATER)));

    always_comb begin
        n_depth      = r_depth;
        n_len        = r_len;
        n_start      = r_start;
        n_ovf        = r_ovf;
        n_pend       = r_pend;
        n_pcol       = r_pcol;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_line       = r_line;
        n_col        = r_col;
        do_flush     = 1'b0;
        do_single    = 1'b0;
        do_append    = 1'b0;
        cmd          = '0;
        cmd.line     = r_line;

        if (accept) begin
            unique case (i_req.action)
                psplit_pkg::ACT_CHAR: begin
                    if (r_pend != psplit_pkg::PEND_NONE) begin
                        cmd.p_valid  = 1'b1;
                        cmd.p_pair   = pend_hit;
                        cmd.p_char   = psplit_pkg::pend_char(r_pend);
                        cmd.p_second = c;
                        cmd.p_col    = r_pcol;
                        n_pend       = psplit_pkg::PEND_NONE;
                    end
                    if (!pend_hit) begin
                        priority if (c == psplit_pkg::CH_LBRACE) begin
                            if (r_depth != '1) begin
                                n_depth = r_depth + 1'b1;
                            end
                            do_flush = 1'b1;
                        end else if (c == psplit_pkg::CH_RBRACE) begin
                            if (r_depth != '0) begin
                                n_depth = r_depth - 1'b1;
                            end
                        end else if (r_depth != '0) begin
                            do_flush = 1'b0;
                        end else begin
                            unique case (c)
                                psplit_pkg::CH_DOT: begin
                                    if (prev_digit) begin
                                        do_append = 1'b1;
                                    end else begin
                                        do_flush  = 1'b1;
                                        do_single = 1'b1;
                                    end
                                end
                                psplit_pkg::CH_COLON, psplit_pkg::CH_LESS,
                                psplit_pkg::CH_GREATER: begin
                                    do_flush = 1'b1;
                                    n_pcol   = col10;
                                    n_pend   = (c == psplit_pkg::CH_COLON) ?
                                               psplit_pkg::PEND_COLON :
                                               (c == psplit_pkg::CH_LESS) ?
                                               psplit_pkg::PEND_LESS :
                                               psplit_pkg::PEND_GREATER;
                                end
                                psplit_pkg::CH_SPACE, psplit_pkg::CH_TAB,
                                psplit_pkg::CH_NL: begin
                                    do_flush = 1'b1;
                                end
                                psplit_pkg::CH_EQUAL, psplit_pkg::CH_SEMI,
                                psplit_pkg::CH_COMMA, psplit_pkg::CH_LPAREN,
                                psplit_pkg::CH_RPAREN, psplit_pkg::CH_PLUS,
                                psplit_pkg::CH_MINUS, psplit_pkg::CH_STAR,
                                psplit_pkg::CH_SLASH: begin
                                    do_flush  = 1'b1;
                                    do_single = 1'b1;
                                end
                                default: begin
                                    do_append = 1'b1;
                                end
                            endcase
                        end
                    end
                    n_prev       = c;
                    n_prev_valid = 1'b1;
                    n_col        = (r_col == CW'(LINE_COLUMNS - 1)) ? '0 : r_col + 1'b1;
                end
                psplit_pkg::ACT_EOL, psplit_pkg::ACT_EOI: begin
                    if (r_pend != psplit_pkg::PEND_NONE) begin
                        cmd.p_valid = 1'b1;
                        cmd.p_char  = psplit_pkg::pend_char(r_pend);
                        cmd.p_col   = r_pcol;
                        n_pend      = psplit_pkg::PEND_NONE;
                    end
                    do_flush = 1'b1;
                    if (i_req.action == psplit_pkg::ACT_EOI) begin
                        cmd.e_valid = 1'b1;
                    end else begin
                        n_line       = r_line + 1'b1;
                        n_col        = '0;
                        n_prev_valid = 1'b0;
                        n_prev       = '0;
                    end
                end
                default: begin
                    cmd.line = r_line;
                end
            endcase
        end

        if (do_flush) begin
            if (r_len != '0) begin
                cmd.f_valid = 1'b1;
                cmd.f_len   = psplit_pkg::LEN_W'(r_len);
                cmd.f_col   = r_start;
                cmd.f_ovf   = r_ovf;
            end
            n_len = '0;
            n_ovf = 1'b0;
        end
        if (do_single) begin
            cmd.s_valid = 1'b1;
            cmd.s_char  = c;
            cmd.s_col   = col10;
        end
        if (do_append) begin
            if (r_len == '0) begin
                n_start = col10;
            end
            if (r_len < LW'(MAX_LEXEME)) begin
                cmd.w_valid = 1'b1;
                cmd.w_idx   = psplit_pkg::IDX_W'(r_len);
                cmd.w_char  = c;
                n_len       = r_len + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.p_valid || cmd.f_valid || cmd.s_valid
                               || cmd.e_valid || cmd.w_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth      <= '0;
            r_len        <= '0;
            r_start      <= '0;
            r_ovf        <= 1'b0;
            r_pend       <= psplit_pkg::PEND_NONE;
            r_pcol       <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_line       <= '0;
            r_col        <= '0;
        end else begin
            r_depth      <= n_depth;
            r_len        <= n_len;
            r_start      <= n_start;
            r_ovf        <= n_ovf;
            r_pend       <= n_pend;
            r_pcol       <= n_pcol;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
            r_line       <= n_line;
            r_col        <= n_col;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/psplit_back.sv -----
// Back end: owns the lexeme buffer and emits queued work one character at a time.
`timescale 1ns / 1ps
`default_nettype none

module psplit_back #(
    parameter int MAX_LEXEME = psplit_pkg::DEF_MAX_LEXEME
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  psplit_pkg::t_cmd i_cmd,
    output logic             o_pop,
    psplit_out_if.source     o_lex
);

    localparam int AW    = $clog2(MAX_LEXEME);
    localparam int LEN_W = psplit_pkg::LEN_W;

    psplit_pkg::t_back_state       r_state, n_state;
    psplit_pkg::t_cmd              r_cmd, n_cmd;
    logic [AW-1:0]                 r_idx, n_idx;
    logic                          r_out_valid;
    psplit_pkg::t_lex              r_out, n_item;
    logic                          load;
    logic                          out_free;
    logic                          ram_re;
    logic                          flush_last;
    logic [psplit_pkg::CHAR_W-1:0] ram_rdata;

    function automatic psplit_pkg::t_back_state after_flush(input psplit_pkg::t_cmd c);
        psplit_pkg::t_back_state s;
        if (c.s_valid) begin
            s = psplit_pkg::BK_SINGLE;
        end else if (c.e_valid) begin
            s = psplit_pkg::BK_END;
        end else begin
            s = psplit_pkg::BK_IDLE;
        end
        return s;
    endfunction

    function automatic psplit_pkg::t_back_state after_pend(input psplit_pkg::t_cmd c);
        psplit_pkg::t_back_state s;
        s = c.f_valid ? psplit_pkg::BK_FLUSH_RD : after_flush(c);
        return s;
    endfunction

    function automatic psplit_pkg::t_back_state first_phase(input psplit_pkg::t_cmd c);
        psplit_pkg::t_back_state s;
        s = c.p_valid ? psplit_pkg::BK_PEND1 : after_pend(c);
        return s;
    endfunction

    psplit_ram #(
        .WIDTH (psplit_pkg::CHAR_W),
        .DEPTH (MAX_LEXEME)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (o_pop && i_cmd.w_valid),
        .i_waddr (i_cmd.w_idx[AW-1:0]),
        .i_wdata (i_cmd.w_char),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign out_free   = !r_out_valid || o_lex.ready;
    assign flush_last = (LEN_W'(r_idx) + LEN_W'(1)) == r_cmd.f_len;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        load        = 1'b0;
        o_pop       = 1'b0;
        ram_re      = 1'b0;
        n_item      = '0;
        n_item.line = r_cmd.line;

        unique case (r_state)
            psplit_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_idx   = '0;
                    n_state = first_phase(i_cmd);
                end
            end
            psplit_pkg::BK_PEND1: begin
                if (out_free) begin
                    load              = 1'b1;
                    n_item.lex_char   = r_cmd.p_char;
                    n_item.first_char = 1'b1;
                    n_item.last_char  = !r_cmd.p_pair;
                    n_item.column     = r_cmd.p_col;
                    n_state = r_cmd.p_pair ? psplit_pkg::BK_PEND2 : after_pend(r_cmd);
                end
            end
            psplit_pkg::BK_PEND2: begin
                if (out_free) begin
                    load             = 1'b1;
                    n_item.lex_char  = r_cmd.p_second;
                    n_item.last_char = 1'b1;
                    n_item.column    = r_cmd.p_col;
                    n_state          = after_pend(r_cmd);
                end
            end
            psplit_pkg::BK_FLUSH_RD: begin
                ram_re  = 1'b1;
                n_state = psplit_pkg::BK_FLUSH_OUT;
            end
            psplit_pkg::BK_FLUSH_OUT: begin
                if (out_free) begin
                    load              = 1'b1;
                    n_item.lex_char   = ram_rdata;
                    n_item.first_char = (r_idx == '0);
                    n_item.last_char  = flush_last;
                    n_item.column     = r_cmd.f_col;
                    n_item.truncated  = r_cmd.f_ovf;
                    if (flush_last) begin
                        n_idx   = '0;
                        n_state = after_flush(r_cmd);
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = psplit_pkg::BK_FLUSH_RD;
                    end
                end
            end
            psplit_pkg::BK_SINGLE: begin
                if (out_free) begin
                    load              = 1'b1;
                    n_item.lex_char   = r_cmd.s_char;
                    n_item.first_char = 1'b1;
                    n_item.last_char  = 1'b1;
                    n_item.column     = r_cmd.s_col;
                    n_state = r_cmd.e_valid ? psplit_pkg::BK_END : psplit_pkg::BK_IDLE;
                end
            end
            psplit_pkg::BK_END: begin
                if (out_free) begin
                    load                = 1'b1;
                    n_item.end_of_input = 1'b1;
                    n_state             = psplit_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = psplit_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psplit_pkg::BK_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_lex.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (load) begin
            r_out <= n_item;
        end
    end

    assign o_lex.valid        = r_out_valid;
    assign o_lex.lex_char     = r_out.lex_char;
    assign o_lex.first_char   = r_out.first_char;
    assign o_lex.last_char    = r_out.last_char;
    assign o_lex.line         = r_out.line;
    assign o_lex.column       = r_out.column;
    assign o_lex.end_of_input = r_out.end_of_input;
    assign o_lex.truncated    = r_out.truncated;

endmodule

`default_nettype wire

// ----- rtl/core/pascal_lexeme_splitter_unit.sv -----
// Top level of the Pascal lexeme splitter: front end, command queue and back end.
//
// Takes one request per cycle (a source character, an end of line or an end of input)
// while its four-entry command queue has room, and streams each lexeme out one
// character per result, tagged with line, start column and first/last/truncated flags.
// Brace comments nest and are skipped; ':' '<' '>' are held one character so that
// := <= >= <> come out as one lexeme. Output rate is set by the back end: each
// character of a buffered lexeme takes a registered read from the lexeme buffer,
// then the output register; every other result goes straight to the output
// register, and each queued request is first taken from the queue while the back end
// is idle, so it takes the next request only once every result of the last is loaded;
// characters that only join a lexeme are written to the buffer as they are taken.
// The lexeme buffer needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module pascal_lexeme_splitter_unit #(
    parameter int MAX_LEXEME   = psplit_pkg::DEF_MAX_LEXEME,
    parameter int LINE_COLUMNS = psplit_pkg::DEF_LINE_COLUMNS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    psplit_in_if.sink     i_req,
    psplit_out_if.source  o_lex
);

    logic             q_push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    psplit_pkg::t_cmd push_cmd;
    psplit_pkg::t_cmd pop_cmd;

    psplit_front #(
        .MAX_LEXEME   (MAX_LEXEME),
        .LINE_COLUMNS (LINE_COLUMNS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    psplit_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (pop_cmd)
    );

    psplit_back #(
        .MAX_LEXEME (MAX_LEXEME)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (pop_cmd),
        .o_pop     (q_pop),
        .o_lex     (o_lex)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_end_item_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_lex.valid && o_lex.end_of_input) |->
        (o_lex.lex_char == '0) && !o_lex.first_char && !o_lex.last_char
        && (o_lex.column == '0) && !o_lex.truncated)
        else $error("end item carries character data");

    a_single_not_truncated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_lex.valid && o_lex.first_char && o_lex.last_char) |-> !o_lex.truncated)
        else $error("one-character lexeme flagged as truncated");

    a_reset_clears_output: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_lex.valid)
        else $error("result valid straight after reset");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for pascal_lexeme_splitter_unit: directed and random source text checked against a lexeme predictor.
`timescale 1ns / 1ps

module testbench;

    localparam logic [psplit_pkg::ACT_W-1:0]  ACT_UNUSED      = 2'd3;
    localparam logic [psplit_pkg::CHAR_W-1:0] CH_LETTER_A     = 8'h61;
    localparam int unsigned                   QUIET_LIMIT     = 4000;
    localparam int unsigned                   TAIL_CYCLES     = 80;
    localparam int unsigned                   RANDOM_REQUESTS = 100;
    localparam int unsigned                   STEADY_CHARS    = 100;
    localparam int unsigned                   REPORT_LINES    = 40;

    logic i_clk;
    logic i_rst_n;

    psplit_in_if  char_if ();
    psplit_out_if lexeme_if ();

    pascal_lexeme_splitter_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (char_if),
        .o_lex   (lexeme_if)
    );

    logic [psplit_pkg::DEPTH_W-1:0] brace_depth;
    logic [psplit_pkg::CHAR_W-1:0]  word_buf [psplit_pkg::DEF_MAX_LEXEME];
    int unsigned                    word_len;
    logic [psplit_pkg::COL_W-1:0]   word_col;
    logic                           word_cut;
    psplit_pkg::t_pend              held_op;
    logic [psplit_pkg::COL_W-1:0]   held_col;
    logic [psplit_pkg::CHAR_W-1:0]  last_byte;
    logic                           last_byte_ok;
    logic [psplit_pkg::LINE_W-1:0]  line_no;
    logic [psplit_pkg::COL_W-1:0]   col_no;

    psplit_pkg::t_lex awaited_lexemes [$];
    int unsigned      mismatch_count = 0;
    int unsigned      requests_sent  = 0;
    bit               steady_run     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void emit(input logic [psplit_pkg::CHAR_W-1:0] c, input logic first,
                                 input logic last, input logic [psplit_pkg::COL_W-1:0] col,
                                 input logic eoi, input logic cut);
        psplit_pkg::t_lex r;
        r.lex_char     = c;
        r.first_char   = first;
        r.last_char    = last;
        r.line         = line_no;
        r.column       = col;
        r.end_of_input = eoi;
        r.truncated    = cut;
        awaited_lexemes.push_back(r);
    endfunction

    function automatic logic [psplit_pkg::CHAR_W-1:0] held_byte();
        case (held_op)
            psplit_pkg::PEND_COLON: return psplit_pkg::CH_COLON;
            psplit_pkg::PEND_LESS:  return psplit_pkg::CH_LESS;
            default:                return psplit_pkg::CH_GREATER;
        endcase
    endfunction

    function automatic void flush_word();
        for (int i = 0; i < word_len; i++) begin
            emit(word_buf[i], i == 0, i + 1 == word_len, word_col, 1'b0, word_cut);
        end
        word_len = 0;
        word_cut = 1'b0;
    endfunction

    function automatic void flush_held();
        if (held_op != psplit_pkg::PEND_NONE) begin
            emit(held_byte(), 1'b1, 1'b1, held_col, 1'b0, 1'b0);
        end
        held_op = psplit_pkg::PEND_NONE;
    endfunction

    function automatic void grow_word(input logic [psplit_pkg::CHAR_W-1:0] c,
                                      input logic [psplit_pkg::COL_W-1:0] col);
        if (word_len == 0) word_col = col;
        if (word_len < psplit_pkg::DEF_MAX_LEXEME) begin
            word_buf[word_len] = c;
            word_len++;
        end else begin
            word_cut = 1'b1;
        end
    endfunction

    function automatic void scan_char(input logic [psplit_pkg::CHAR_W-1:0] c,
                                      input logic [psplit_pkg::COL_W-1:0] col);
        if (held_op != psplit_pkg::PEND_NONE) begin
            if (c == psplit_pkg::CH_EQUAL
                || (held_op == psplit_pkg::PEND_LESS && c == psplit_pkg::CH_GREATER)) begin
                emit(held_byte(), 1'b1, 1'b0, held_col, 1'b0, 1'b0);
                emit(c, 1'b0, 1'b1, held_col, 1'b0, 1'b0);
                held_op = psplit_pkg::PEND_NONE;
                return;
            end
            flush_held();
        end
        if (c == psplit_pkg::CH_LBRACE) begin
            if (brace_depth != '1) brace_depth++;
            flush_word();
            return;
        end
        if (c == psplit_pkg::CH_RBRACE) begin
            if (brace_depth != '0) brace_depth--;
            return;
        end
        if (brace_depth != '0) return;
        case (c)
            psplit_pkg::CH_DOT: begin
                if (last_byte_ok && last_byte >= psplit_pkg::CH_ZERO
                    && last_byte <= psplit_pkg::CH_NINE) begin
                    grow_word(c, col);
                end else begin
                    flush_word();
                    emit(c, 1'b1, 1'b1, col, 1'b0, 1'b0);
                end
            end
            psplit_pkg::CH_COLON, psplit_pkg::CH_LESS, psplit_pkg::CH_GREATER: begin
                flush_word();
                if (c == psplit_pkg::CH_COLON) held_op = psplit_pkg::PEND_COLON;
                else if (c == psplit_pkg::CH_LESS) held_op = psplit_pkg::PEND_LESS;
                else held_op = psplit_pkg::PEND_GREATER;
                held_col = col;
            end
            psplit_pkg::CH_SPACE, psplit_pkg::CH_TAB, psplit_pkg::CH_NL: begin
                flush_word();
            end
            psplit_pkg::CH_EQUAL, psplit_pkg::CH_SEMI, psplit_pkg::CH_COMMA,
            psplit_pkg::CH_LPAREN, psplit_pkg::CH_RPAREN, psplit_pkg::CH_PLUS,
            psplit_pkg::CH_MINUS, psplit_pkg::CH_STAR, psplit_pkg::CH_SLASH: begin
                flush_word();
                emit(c, 1'b1, 1'b1, col, 1'b0, 1'b0);
            end
            default: begin
                grow_word(c, col);
            end
        endcase
    endfunction

    function automatic void predict_lexemes(input logic [psplit_pkg::ACT_W-1:0] act,
                                            input logic [psplit_pkg::CHAR_W-1:0] c);
        if (act == psplit_pkg::ACT_CHAR) begin
            scan_char(c, col_no);
            last_byte    = c;
            last_byte_ok = 1'b1;
            col_no = (int'(col_no) + 1 >= psplit_pkg::DEF_LINE_COLUMNS) ? '0 : col_no + 1'b1;
        end else if (act == psplit_pkg::ACT_EOL) begin
            flush_held();
            flush_word();
            line_no++;
            col_no       = '0;
            last_byte_ok = 1'b0;
            last_byte    = '0;
        end else if (act == psplit_pkg::ACT_EOI) begin
            flush_held();
            flush_word();
            emit('0, 1'b0, 1'b0, '0, 1'b1, 1'b0);
        end
    endfunction

    function automatic int unsigned idle_gap();
        if (steady_run || $urandom_range(99) >= 30) return 0;
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [psplit_pkg::CHAR_W-1:0] any_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [psplit_pkg::CHAR_W-1:0] word_byte();
        if ($urandom_range(1) == 0) return CH_LETTER_A + 8'($urandom_range(25));
        return psplit_pkg::CH_ZERO + 8'($urandom_range(9));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES) begin
            $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(name, got, want);
    endtask

    // hold the request until accepted, then predict its lexemes
    task automatic send_request(input logic [psplit_pkg::ACT_W-1:0] act,
                                input logic [psplit_pkg::CHAR_W-1:0] c);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0) begin
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_if.valid  <= 1'b1;
        char_if.action <= act;
        char_if.ch     <= c;
        do @(posedge i_clk); while (char_if.ready !== 1'b1);
        if (act != ACT_UNUSED) requests_sent++;
        predict_lexemes(act, c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_request(psplit_pkg::ACT_CHAR, s[i]);
    endtask

    task automatic hold_until_drained();
        char_if.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_lexemes.size() != 0);
    endtask

    task automatic test_operators_and_delimiters();
        send_text(":=<=>=<><a>>");
        send_request(psplit_pkg::ACT_EOL, any_byte());
        send_text("(a;b,c)+-*/=d");
        send_request(psplit_pkg::ACT_EOL, any_byte());
    endtask

    task automatic test_comment_nesting();
        send_text("a}b{{x");
        send_request(psplit_pkg::ACT_EOL, any_byte());
        send_text("y}}}:{=} ");
        send_request(psplit_pkg::ACT_EOI, any_byte());
    endtask

    task automatic test_dots_and_separators();
        send_text("1.5.x");
        send_request(psplit_pkg::ACT_CHAR, psplit_pkg::CH_TAB);
        send_request(psplit_pkg::ACT_CHAR, psplit_pkg::CH_DOT);
        send_request(psplit_pkg::ACT_CHAR, psplit_pkg::CH_NL);
        send_text("9");
        send_request(psplit_pkg::ACT_EOL, any_byte());
        send_request(psplit_pkg::ACT_CHAR, psplit_pkg::CH_DOT);
        send_request(psplit_pkg::ACT_CHAR, 8'h00);
        send_request(psplit_pkg::ACT_CHAR, 8'hFF);
        send_request(ACT_UNUSED, any_byte());
        send_text(" 7.");
        send_request(psplit_pkg::ACT_EOI, any_byte());
        send_request(psplit_pkg::ACT_EOI, any_byte());
    endtask

    task automatic test_depth_limits();
        repeat (6) send_request(psplit_pkg::ACT_CHAR, psplit_pkg::CH_LBRACE);
        send_text("z:=");
        repeat (8) send_request(psplit_pkg::ACT_CHAR, psplit_pkg::CH_RBRACE);
        send_text("q");
        send_request(psplit_pkg::ACT_EOL, any_byte());
    endtask

    task automatic test_lexeme_truncation();
        int unsigned lengths [3];
        lengths = '{31, 32, 33};
        foreach (lengths[k]) begin
            repeat (lengths[k]) begin
                send_request(psplit_pkg::ACT_CHAR, CH_LETTER_A + 8'($urandom_range(25)));
            end
            send_request(psplit_pkg::ACT_CHAR, psplit_pkg::CH_SEMI);
        end
        send_request(psplit_pkg::ACT_EOL, any_byte());
    endtask

    // run without idling on either side
    task automatic test_steady_stream();
        steady_run = 1'b1;
        for (int i = 0; i < STEADY_CHARS; i++) begin
            if (i % 6 == 5) send_request(psplit_pkg::ACT_CHAR, psplit_pkg::CH_SPACE);
            else send_request(psplit_pkg::ACT_CHAR, CH_LETTER_A + 8'(i % 26));
        end
        send_request(psplit_pkg::ACT_EOL, any_byte());
        steady_run = 1'b0;
    endtask

    task automatic send_fragment();
        int unsigned kind;
        int unsigned len;
        string       delims = ";,()+-*/";
        string       seps   = " \t\n";
        kind = $urandom_range(99);
        len  = $urandom_range(8, 1);
        if (kind < 30) begin
            send_request(psplit_pkg::ACT_CHAR, CH_LETTER_A + 8'($urandom_range(25)));
            repeat (len - 1) send_request(psplit_pkg::ACT_CHAR, word_byte());
        end else if (kind < 42) begin
            repeat (len) begin
                send_request(psplit_pkg::ACT_CHAR, psplit_pkg::CH_ZERO + 8'($urandom_range(9)));
            end
            if ($urandom_range(1) == 0) begin
                send_request(psplit_pkg::ACT_CHAR, psplit_pkg::CH_DOT);
                repeat ($urandom_range(3)) begin
                    send_request(psplit_pkg::ACT_CHAR,
                                 psplit_pkg::CH_ZERO + 8'($urandom_range(9)));
                end
            end
        end else if (kind < 55) begin
            case ($urandom_range(8))
                0: send_text(":=");
                1: send_text("<=");
                2: send_text(">=");
                3: send_text("<>");
                4: send_text("<");
                5: send_text(">");
                6: send_text(":");
                7: send_text("=");
                default: send_text(".");
            endcase
        end else if (kind < 67) begin
            send_request(psplit_pkg::ACT_CHAR, delims[$urandom_range(7)]);
        end else if (kind < 77) begin
            send_request(psplit_pkg::ACT_CHAR, seps[$urandom_range(2)]);
        end else if (kind < 83) begin
            send_request(psplit_pkg::ACT_CHAR, psplit_pkg::CH_LBRACE);
            repeat (len) begin
                if ($urandom_range(5) == 0) send_text("{x}");
                else send_request(psplit_pkg::ACT_CHAR, word_byte());
            end
            send_request(psplit_pkg::ACT_CHAR, psplit_pkg::CH_RBRACE);
        end else if (kind < 90) begin
            send_request(psplit_pkg::ACT_EOL, any_byte());
        end else if (kind < 92) begin
            send_request(psplit_pkg::ACT_EOI, any_byte());
        end else begin
            case ($urandom_range(4))
                0: send_request(psplit_pkg::ACT_CHAR, any_byte());
                1: send_request(ACT_UNUSED, any_byte());
                2, 3: send_request(psplit_pkg::ACT_CHAR, psplit_pkg::CH_RBRACE);
                default: send_request(psplit_pkg::ACT_CHAR, psplit_pkg::CH_LBRACE);
            endcase
        end
    endtask

    task automatic test_random_source();
        int unsigned start;
        for (int half = 0; half < 2; half++) begin
            start = requests_sent;
            while (requests_sent - start < RANDOM_REQUESTS / 2) send_fragment();
            hold_until_drained();
        end
    endtask

    initial begin : result_check
        psplit_pkg::t_lex want;
        lexeme_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && lexeme_if.valid && lexeme_if.ready) begin
                if (awaited_lexemes.size() == 0) begin
                    report_mismatch("result with nothing awaited", lexeme_if.lex_char, '0);
                end else begin
                    want = awaited_lexemes.pop_front();
                    check_field("lex_char", lexeme_if.lex_char, want.lex_char);
                    check_field("first_char", lexeme_if.first_char, want.first_char);
                    check_field("last_char", lexeme_if.last_char, want.last_char);
                    check_field("line", lexeme_if.line, want.line);
                    check_field("column", lexeme_if.column, want.column);
                    check_field("end_of_input", lexeme_if.end_of_input, want.end_of_input);
                    check_field("truncated", lexeme_if.truncated, want.truncated);
                end
            end
            lexeme_if.ready <= steady_run || ($urandom_range(99) >= 30);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((char_if.valid && char_if.ready) || (lexeme_if.valid && lexeme_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL pascal_lexeme_splitter_unit");
        $finish;
    end

    initial begin
        i_rst_n        <= 1'b0;
        char_if.valid  <= 1'b0;
        char_if.action <= psplit_pkg::ACT_CHAR;
        char_if.ch     <= '0;
        brace_depth  = '0;
        word_len     = 0;
        word_col     = '0;
        word_cut     = 1'b0;
        held_op      = psplit_pkg::PEND_NONE;
        held_col     = '0;
        last_byte    = '0;
        last_byte_ok = 1'b0;
        line_no      = '0;
        col_no       = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_operators_and_delimiters();
        test_comment_nesting();
        hold_until_drained();
        test_dots_and_separators();
        test_depth_limits();
        test_lexeme_truncation();
        hold_until_drained();
        test_steady_stream();
        test_random_source();

        char_if.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_lexemes.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS pascal_lexeme_splitter_unit");
        end else begin
            $display("FAIL pascal_lexeme_splitter_unit");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/psplit_pkg.sv
rtl/core/psplit_in_if.sv
rtl/core/psplit_out_if.sv
rtl/core/psplit_ram.sv
rtl/core/psplit_cmd_fifo.sv
rtl/core/psplit_front.sv
rtl/core/psplit_back.sv
rtl/core/pascal_lexeme_splitter_unit.sv
sim/testbench.sv
